[rtl/ism_pkg.sv]
// ----------------------------------------------------------------------------
// ism_pkg
// Types and constants shared by the interval sort-and-merge block.
// ----------------------------------------------------------------------------
package ism_pkg;

  // Width of an interval end point.
  localparam int DATA_W = 32;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // One input beat: a closed interval and the end-of-set mark.
  typedef struct packed {
    logic signed [DATA_W-1:0] interval_begin;
    logic signed [DATA_W-1:0] interval_end;
    logic                     last_interval;
  } in_t;

  // One output beat: a merged interval with its marks.
  typedef struct packed {
    logic signed [DATA_W-1:0] merged_begin;
    logic signed [DATA_W-1:0] merged_end;
    logic                     last_merged;
    logic                     overflow;
  } out_t;

endpackage

[rtl/ism_front.sv]
// ----------------------------------------------------------------------------
// ism_front
// Input side: accepts interval beats into a short queue so that the sorter
// and merger behind it can stall without blocking upstream until it fills.
// ----------------------------------------------------------------------------
module ism_front
  import ism_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic q_valid,
  input  logic q_pop,
  output in_t  q_data
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  in_t           slot [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [FW-1:0] fill;
  logic          push;
  logic          pop;

  // The queue stalls the upstream side only when every slot is taken.
  assign in_stall = (fill == FW'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != '0);
  assign pop      = q_pop && q_valid;
  assign q_data   = slot[rd_ptr];

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[rtl/ism_back.sv]
// ----------------------------------------------------------------------------
// ism_back
// Sorter and merger: inserts queued intervals into a row of sorted cells,
// one per cycle, then walks the row, merging overlaps into an output register.
// ----------------------------------------------------------------------------
module ism_back
  import ism_pkg::*;
#(
  parameter int MAX_INTERVALS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_pop,
  input  in_t  q_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int CW = $clog2(MAX_INTERVALS + 1);

  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_FIRST = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;

  logic [1:0]               state;
  logic signed [DATA_W-1:0] begin_cell [MAX_INTERVALS];
  logic signed [DATA_W-1:0] end_cell   [MAX_INTERVALS];
  logic [CW-1:0]            stored_count;
  logic [CW-1:0]            remain;
  logic                     dropped_flag;
  logic signed [DATA_W-1:0] run_begin;
  logic signed [DATA_W-1:0] run_end;

  logic [MAX_INTERVALS-1:0] greater;
  logic [MAX_INTERVALS-1:0] take_prev;
  logic [MAX_INTERVALS-1:0] take_new;
  logic                     full;
  logic                     ins_en;
  logic                     shift_en;
  logic                     joins;
  logic                     out_free;
  logic                     emit;

  assign full     = (stored_count == CW'(MAX_INTERVALS));
  assign q_pop    = (state == S_LOAD) && q_valid;
  assign ins_en   = q_pop && !full;
  assign out_free = !out_valid || !out_stall;
  assign joins    = (begin_cell[0] <= run_end);
  assign emit     = (state == S_WALK) && out_free && ((remain == '0) || !joins);
  assign shift_en = (state == S_FIRST) ||
                    ((state == S_WALK) && (remain != '0) && (joins || out_free));

  // Every valid cell compares its begin with the new one in parallel. Cells
  // above the insertion point move up; equal begins keep arrival order.
  always_comb begin
    for (int i = 0; i < MAX_INTERVALS; i++) begin
      greater[i] = (CW'(i) < stored_count) && (begin_cell[i] > q_data.interval_begin);
    end
    take_prev[0] = 1'b0;
    take_new[0]  = greater[0] || (stored_count == '0);
    for (int i = 1; i < MAX_INTERVALS; i++) begin
      take_prev[i] = greater[i-1];
      take_new[i]  = !greater[i-1] && (greater[i] || (stored_count == CW'(i)));
    end
  end

  // Cell row: insert while loading, shift toward cell zero while walking.
  always_ff @(posedge clk) begin
    if (ins_en) begin
      for (int i = 0; i < MAX_INTERVALS; i++) begin
        if (take_prev[i]) begin
          begin_cell[i] <= begin_cell[(i > 0) ? i - 1 : 0];
          end_cell[i]   <= end_cell[(i > 0) ? i - 1 : 0];
        end else if (take_new[i]) begin
          begin_cell[i] <= q_data.interval_begin;
          end_cell[i]   <= q_data.interval_end;
        end
      end
    end else if (shift_en) begin
      for (int i = 0; i < MAX_INTERVALS - 1; i++) begin
        begin_cell[i] <= begin_cell[i+1];
        end_cell[i]   <= end_cell[i+1];
      end
    end
  end

  // Sequencer for loading and the merge walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      stored_count <= '0;
      remain       <= '0;
      dropped_flag <= 1'b0;
      run_begin    <= '0;
      run_end      <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (q_pop) begin
            if (full) begin
              dropped_flag <= 1'b1;
            end else begin
              stored_count <= stored_count + 1'b1;
            end
            if (q_data.last_interval) begin
              state <= S_FIRST;
            end
          end
        end
        S_FIRST: begin
          run_begin <= begin_cell[0];
          run_end   <= end_cell[0];
          remain    <= stored_count - 1'b1;
          state     <= S_WALK;
        end
        S_WALK: begin
          if (remain == '0) begin
            if (out_free) begin
              stored_count <= '0;
              dropped_flag <= 1'b0;
              state        <= S_LOAD;
            end
          end else if (joins) begin
            if (end_cell[0] > run_end) begin
              run_end <= end_cell[0];
            end
            remain <= remain - 1'b1;
          end else if (out_free) begin
            run_begin <= begin_cell[0];
            run_end   <= end_cell[0];
            remain    <= remain - 1'b1;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // Output register: holds a merged interval until the downstream takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.merged_begin <= run_begin;
      out_data.merged_end   <= run_end;
      out_data.last_merged  <= (remain == '0);
      out_data.overflow     <= dropped_flag;
    end
  end

  // The fill count never passes the row size.
  assert property (@(posedge clk) disable iff (rst)
    stored_count <= CW'(MAX_INTERVALS))
    else $error("stored count beyond capacity");

  // A drain always has at least one interval to walk.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_FIRST || state == S_WALK) |-> stored_count != '0)
    else $error("drain started on an empty set");

  // The first two cells stay in ascending order while loading.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD && stored_count >= CW'(2) && MAX_INTERVALS > 1)
      |-> begin_cell[0] <= begin_cell[(MAX_INTERVALS > 1) ? 1 : 0])
    else $error("cell row out of order");

  // Emitting the final merged interval returns the block to an empty load.
  assert property (@(posedge clk) disable iff (rst)
    (emit && remain == '0) |=> (state == S_LOAD && stored_count == '0 && !dropped_flag))
    else $error("set not closed after final merged interval");

endmodule

[rtl/interval_sort_merge.sv]
// ----------------------------------------------------------------------------
// interval_sort_merge
// Sorts a set of closed intervals by begin and emits the merged intervals.
// ----------------------------------------------------------------------------
// Intervals are loaded at one beat per cycle unless in_stall is high:
// each beat enters a two-entry queue and is inserted into a row of
// MAX_INTERVALS sorted cells by parallel compares. The beat marked
// last_interval closes the set; the back end then walks the cells, one
// per cycle unless the output is stalled, and input beats of the next
// set wait in the queue meanwhile.
// Intervals beyond MAX_INTERVALS are dropped and every merged interval of
// that set carries overflow. The final merged interval has last_merged set.
module interval_sort_merge
  import ism_pkg::*;
#(
  parameter int MAX_INTERVALS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic q_valid;
  logic q_pop;
  in_t  q_data;

  // Input queue.
  ism_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_data)
  );

  // Sorter and merger.
  ism_back #(
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for interval_sort_merge: drives sets of intervals,
// predicts the merged intervals of each set and checks every output beat.
// ----------------------------------------------------------------------------
module tb
  import ism_pkg::*;
();

  localparam int CAPACITY = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 220;
  localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // Predicted state of the current set, kept sorted by begin.
  logic signed [DATA_W-1:0] set_begin [CAPACITY];
  logic signed [DATA_W-1:0] set_end [CAPACITY];
  int set_size = 0;
  bit set_dropped = 1'b0;
  out_t merged_due [$];

  // Control of the idle behavior on both sides.
  bit tx_idles = 1'b1;
  bit rx_idles = 1'b1;
  logic pressure_hold = 1'b0;
  int rx_wait_left = 0;

  int failures = 0;
  int items_sent = 0;
  int cycles = 0;

  interval_sort_merge #(
    .MAX_INTERVALS(CAPACITY)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stop the run if it hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Insert one accepted interval into the predicted set and, on the final
  // beat of the set, queue the merged intervals that must come out.
  task automatic absorb_interval(input in_t beat);
    int pos;
    logic signed [DATA_W-1:0] new_begin;
    logic signed [DATA_W-1:0] new_end;
    logic signed [DATA_W-1:0] span_begin;
    logic signed [DATA_W-1:0] span_end;
    out_t merged;
    new_begin = beat.interval_begin;
    new_end = beat.interval_end;
    if (set_size < CAPACITY) begin
      pos = set_size;
      // Equal begins keep arrival order, so the new one goes after them.
      while (pos > 0 && set_begin[pos-1] > new_begin) begin
        set_begin[pos] = set_begin[pos-1];
        set_end[pos] = set_end[pos-1];
        pos--;
      end
      set_begin[pos] = new_begin;
      set_end[pos] = new_end;
      set_size++;
    end else begin
      set_dropped = 1'b1;
    end
    if (beat.last_interval) begin
      span_begin = set_begin[0];
      span_end = set_end[0];
      for (int i = 1; i < set_size; i++) begin
        if (set_begin[i] <= span_end) begin
          if (set_end[i] > span_end) begin
            span_end = set_end[i];
          end
        end else begin
          merged.merged_begin = span_begin;
          merged.merged_end = span_end;
          merged.last_merged = 1'b0;
          merged.overflow = set_dropped;
          merged_due = {merged_due, merged};
          span_begin = set_begin[i];
          span_end = set_end[i];
        end
      end
      merged.merged_begin = span_begin;
      merged.merged_end = span_end;
      merged.last_merged = 1'b1;
      merged.overflow = set_dropped;
      merged_due = {merged_due, merged};
      set_size = 0;
      set_dropped = 1'b0;
    end
  endtask

  // Offer one interval after a random gap and wait until it is taken.
  // Valid stays high afterwards so that back-to-back beats need no gap.
  task automatic send_interval(input logic signed [DATA_W-1:0] b,
                               input logic signed [DATA_W-1:0] e,
                               input bit last);
    int gap;
    in_t beat;
    gap = tx_idles ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    beat.interval_begin = b;
    beat.interval_end = e;
    beat.last_interval = last;
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (in_stall);
    absorb_interval(beat);
    items_sent++;
  endtask

  // Wait until every predicted merged interval has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (merged_due.size() != 0) @(posedge clk);
  endtask

  // Hold the output side off, then release it.
  task automatic hold_off_output(input int span);
    pressure_hold <= 1'b1;
    repeat (span) @(posedge clk);
    pressure_hold <= 1'b0;
  endtask

  // Output side: check each accepted beat and draw the stall before the next.
  always @(posedge clk) begin
    out_t due;
    if (rst) begin
      rx_wait_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (merged_due.size() == 0) begin
          $error("unexpected merged interval %0d..%0d", $signed(out_data.merged_begin),
                 $signed(out_data.merged_end));
          failures++;
        end else begin
          due = merged_due.pop_front();
          if (out_data.merged_begin !== due.merged_begin) begin
            $error("merged_begin: expected %0d, actual %0d", $signed(due.merged_begin),
                   $signed(out_data.merged_begin));
            failures++;
          end
          if (out_data.merged_end !== due.merged_end) begin
            $error("merged_end: expected %0d, actual %0d", $signed(due.merged_end),
                   $signed(out_data.merged_end));
            failures++;
          end
          if (out_data.last_merged !== due.last_merged) begin
            $error("last_merged: expected %0b, actual %0b", due.last_merged,
                   out_data.last_merged);
            failures++;
          end
          if (out_data.overflow !== due.overflow) begin
            $error("overflow: expected %0b, actual %0b", due.overflow, out_data.overflow);
            failures++;
          end
        end
        rx_wait_left = rx_idles ? $urandom_range(0, 18) : 0;
      end else if (rx_wait_left > 0) begin
        rx_wait_left--;
      end
      out_stall <= pressure_hold || (rx_wait_left != 0);
    end
  end

  // Single-interval sets at the extremes, including an inverted interval.
  task automatic test_single_sets();
    send_interval(MOST_NEG, MOST_POS, 1'b1);
    send_interval(MOST_POS, MOST_NEG, 1'b1);
    send_interval(0, 0, 1'b1);
    wait_drained();
  endtask

  // Touching, adjacent, nested and equal-begin intervals.
  task automatic test_merge_rules();
    send_interval(20, 30, 1'b0);
    send_interval(10, 20, 1'b0);
    send_interval(31, 40, 1'b0);
    send_interval(35, 36, 1'b0);
    send_interval(MOST_NEG, MOST_NEG + 1, 1'b1);
    // An inverted interval ahead of an equal begin closes the run.
    send_interval(5, 3, 1'b0);
    send_interval(5, 9, 1'b0);
    send_interval(5, 1, 1'b1);
    send_interval(MOST_POS - 1, MOST_POS, 1'b0);
    send_interval(MOST_POS, MOST_POS, 1'b0);
    send_interval(-1, 0, 1'b0);
    send_interval(0, -1, 1'b1);
    send_interval(32'sh5555_5555, 32'sh2AAA_AAAA, 1'b0);
    send_interval(32'shAAAA_AAAA, 32'shD555_5555, 1'b1);
    wait_drained();
  endtask

  // Send one set of random intervals; the content style is drawn per set.
  task automatic random_set(input int count);
    int unsigned style;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] e;
    logic signed [DATA_W-1:0] swap;
    style = $urandom_range(0, 9);
    for (int k = 0; k < count; k++) begin
      case (style)
        5, 6: begin
          b = $urandom;
          e = $urandom;
          if (b > e) begin
            swap = b;
            b = e;
            e = swap;
          end
        end
        7: begin
          b = $urandom;
          e = $urandom;
        end
        8: begin
          b = $urandom_range(0, 1) ? MOST_POS - $urandom_range(0, 8)
                                   : MOST_NEG + $urandom_range(0, 8);
          e = $urandom_range(0, 1) ? MOST_POS - $urandom_range(0, 8) : b;
        end
        default: begin
          b = $urandom_range(0, 120) - 60;
          e = b + $urandom_range(0, 15);
          if (style == 9 && $urandom_range(0, 4) == 0) begin
            swap = b;
            b = e;
            e = swap;
          end
        end
      endcase
      send_interval(b, e, k == count - 1);
    end
  endtask

  // Sets that fill the store exactly and sets that spill over it.
  task automatic test_overflow();
    random_set(CAPACITY);
    random_set(CAPACITY + 1);
    random_set(CAPACITY + 5);
    wait_drained();
  endtask

  // The output side holds off for a long time while sets keep coming in.
  task automatic test_output_pressure();
    tx_idles = 1'b0;
    fork
      hold_off_output(300);
    join_none
    repeat (3) random_set(8);
    wait_drained();
    tx_idles = 1'b1;
  endtask

  // Random sets, mostly short, with idling switched on and off in stretches.
  task automatic test_random_sets();
    int start_count;
    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) tx_idles = !tx_idles;
      if ($urandom_range(0, 5) == 0) rx_idles = !rx_idles;
      if ($urandom_range(0, 11) == 0) begin
        random_set($urandom_range(20, 40));
      end else begin
        random_set($urandom_range(1, 8));
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_sets();
    test_merge_rules();
    test_overflow();
    test_output_pressure();
    test_random_sets();
    // Give the block time to show any stray beat.
    repeat (100) @(posedge clk);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[interval_sort_merge.f]
rtl/ism_pkg.sv
rtl/ism_front.sv
rtl/ism_back.sv
rtl/interval_sort_merge.sv
test/tb.sv
